// ===== rtl/voice_gated_alaw_codec_assert.svh =====
// ----------------------------------------------------------------------------
// voice gated a-law codec assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef VOICE_GATED_ALAW_CODEC_ASSERT_SVH
`define VOICE_GATED_ALAW_CODEC_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked at every edge out of reset
`define VGAC_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// consequence checked as a non-overlapping implication of the antecedent
`define VGAC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define VGAC_ASSERT(lbl, ck, rn, prop, msg)

`define VGAC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== rtl/vgac_pkg.sv =====
// ----------------------------------------------------------------------------
// vgac_pkg
// shared types and constants of the voice gated a-law codec
// ----------------------------------------------------------------------------
`default_nettype none

package vgac_pkg;

  localparam int BYTE_W  = 8;
  localparam int LVL_W   = 7;
  localparam int HANG_W  = 16;
  localparam int QRUN_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0] ALAW_XOR = 8'hAA;
  localparam logic [LVL_W-1:0]  MAG_SAT  = 7'd127;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIRECTION   = 2'd0,
    REG_OPEN_LEVEL  = 2'd1,
    REG_CLOSE_LEVEL = 2'd2,
    REG_HANG_COUNT  = 2'd3
  } vgac_reg_t;

  // per-transfer control from the gate to the datapath
  typedef struct packed {
    logic pop;     // oldest held byte is read out of the ring
    logic push;    // converted byte is written into the ring
    logic bypass;  // gating off, converted byte goes straight out
  } vgac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/voice_gated_alaw_codec.sv =====
// Voice gated A-law byte codec.
// Input channel in_*: one byte per transfer in in_tdata, a signed linear
// sample when encoding or an A-law code when decoding. Result channel out_*:
// at most one converted byte per input transfer, in input order.
// Configuration channel cfg_*: cfg_index picks direction (0), open_level (1),
// close_level (2) or hang_count (3); cfg_data is written on a transfer and
// cfg_ready is always high. Write configuration only while the block is idle.
// Throughput: one input transfer per cycle while the output is not stalled,
// set by the single read and single write of the hold ring memory per byte.
// A result that an input transfer releases passes through the ring read stage
// and then the output register before it shows on out_tvalid. With the gate
// open, a byte is released after the effective hang in transfers: hang_count,
// with zero taken as one and values above the ring depth clipped to it.
// Reset: configuration goes to zero (encode, gating off), gate open, ring
// empty; ring contents are not cleared and no clearing pass runs.
// Stall: a held output does not block input; the ring read stage still takes
// one more result, after which in_tready drops until out_tready returns.
// ----------------------------------------------------------------------------
// voice_gated_alaw_codec
// top level: configuration, conversion, gate, hold ring and output stages
// ----------------------------------------------------------------------------
`default_nettype none

module voice_gated_alaw_codec
  import vgac_pkg::*;
#(
  parameter int HOLD_DEPTH = 8192
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [BYTE_W-1:0]     in_tdata,   // [7:0] sample_in
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [BYTE_W-1:0]     out_tdata,  // [7:0] sample_out
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "voice_gated_alaw_codec_assert.svh"

  localparam int ADDR_W = $clog2(HOLD_DEPTH);
  localparam int FILL_W = $clog2(HOLD_DEPTH + 1);

  // configuration registers
  logic              direction_r;
  logic [LVL_W-1:0]  open_level_r;
  logic [LVL_W-1:0]  close_level_r;
  logic [HANG_W-1:0] hang_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r   <= 1'b0;
      open_level_r  <= '0;
      close_level_r <= '0;
      hang_count_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vgac_reg_t'(cfg_index))
        REG_DIRECTION:   direction_r   <= cfg_data[0];
        REG_OPEN_LEVEL:  open_level_r  <= cfg_data[LVL_W-1:0];
        REG_CLOSE_LEVEL: close_level_r <= cfg_data[LVL_W-1:0];
        REG_HANG_COUNT:  hang_count_r  <= cfg_data[HANG_W-1:0];
      endcase
    end
  end

  // handshake and stage control
  logic              in_fire;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mem_r;         // result comes from the ring read
  logic [BYTE_W-1:0] s1_byte_r;        // bypassed converted byte
  logic              s1_move;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;

  // conversion, gate and ring
  logic [BYTE_W-1:0] conv;
  logic [BYTE_W-1:0] mag;
  vgac_ctl_t         ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] rd_data;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_fire   = in_tvalid && in_tready;

  vgac_conv u_conv (
    .direction (direction_r),
    .sample    (in_tdata),
    .conv      (conv),
    .mag       (mag)
  );

  vgac_gate #(
    .HOLD_DEPTH (HOLD_DEPTH),
    .ADDR_W     (ADDR_W),
    .FILL_W     (FILL_W)
  ) u_gate (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .mag         (mag),
    .open_level  (open_level_r),
    .close_level (close_level_r),
    .hang_count  (hang_count_r),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  vgac_ram #(
    .DEPTH  (HOLD_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ctl.pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (ctl.push),
    .wr_addr (wr_addr),
    .wr_data (conv)
  );

  // ring read stage holds one result; read data stays until the next pop
  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = ctl.pop || ctl.bypass;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mem_r  <= ctl.pop;
      s1_byte_r <= conv;
    end
    if (s1_move) begin
      out_data_r <= s1_mem_r ? rd_data : s1_byte_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VGAC_ASSERT_NEXT(a_pop_lands, clk, rst_n, ctl.pop, s1_valid_r && s1_mem_r, "ring read lost")
  `VGAC_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> (s1_valid_r && out_valid_r), "input blocked with room")

endmodule

`default_nettype wire

// ===== rtl/vgac_conv.sv =====
// ----------------------------------------------------------------------------
// vgac_conv
// a-law byte conversion in either direction plus linear magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module vgac_conv
  import vgac_pkg::*;
(
  input  wire logic              direction,
  input  wire logic [BYTE_W-1:0] sample,
  output logic      [BYTE_W-1:0] conv,
  output logic      [BYTE_W-1:0] mag
);

  function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[BYTE_W-1-i] = v[i];
    end
    return r;
  endfunction

  // magnitude of a signed byte, -128 gives 128
  function automatic logic [BYTE_W-1:0] mag8(input logic [BYTE_W-1:0] b);
    return b[BYTE_W-1] ? (~b + 8'd1) : b;
  endfunction

  logic [BYTE_W-1:0] enc_mag;
  logic [LVL_W-1:0]  enc_sat;
  logic [BYTE_W-1:0] enc_code;
  logic [BYTE_W-1:0] dec_v;
  logic [BYTE_W-1:0] dec_mir;
  logic [BYTE_W-1:0] dec_lin;

  always_comb begin
    enc_mag  = mag8(sample);
    enc_sat  = enc_mag[BYTE_W-1] ? MAG_SAT : enc_mag[LVL_W-1:0];
    enc_code = (mirror8({1'b0, enc_sat}) | {7'd0, ~sample[BYTE_W-1]}) ^ ALAW_XOR;

    dec_v   = sample ^ ALAW_XOR;
    dec_mir = mirror8(dec_v);
    dec_lin = dec_v[0] ? {1'b0, dec_mir[LVL_W-1:0]} : (8'd0 - dec_mir);

    conv = direction ? dec_lin : enc_code;
    mag  = direction ? mag8(dec_lin) : enc_mag;
  end

endmodule

`default_nettype wire

// ===== rtl/vgac_ram.sv =====
// ----------------------------------------------------------------------------
// vgac_ram
// hold ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module vgac_ram
  import vgac_pkg::*;
#(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [BYTE_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [BYTE_W-1:0] wr_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // read-first: a read and a write to one entry in the same cycle return old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vgac_gate.sv =====
// ----------------------------------------------------------------------------
// vgac_gate
// voice gate state and hold ring pointers
// ----------------------------------------------------------------------------
`default_nettype none

module vgac_gate
  import vgac_pkg::*;
#(
  parameter int HOLD_DEPTH = 8192,
  parameter int ADDR_W     = 13,
  parameter int FILL_W     = 14
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [BYTE_W-1:0] mag,
  input  wire logic [LVL_W-1:0]  open_level,
  input  wire logic [LVL_W-1:0]  close_level,
  input  wire logic [HANG_W-1:0] hang_count,
  output vgac_ctl_t              ctl,
  output logic      [ADDR_W-1:0] rd_addr,
  output logic      [ADDR_W-1:0] wr_addr
);

`include "voice_gated_alaw_codec_assert.svh"

  localparam int CMP_W = (FILL_W > QRUN_W) ? FILL_W : QRUN_W;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              gate_open_r, gate_open_nxt;
  logic [QRUN_W-1:0] qrun_r, qrun_nxt;

  logic [CMP_W-1:0]  hc_ext;
  logic [CMP_W-1:0]  depth_ext;
  logic [CMP_W-1:0]  hang_ext;
  logic              fill_at_hang;
  logic [ADDR_W-1:0] head_inc;
  logic [FILL_W:0]   wr_sum;
  logic [QRUN_W-1:0] qrun_upd;

  // effective hang, 1 for zero and clipped at ring depth
  always_comb begin
    hc_ext    = CMP_W'(hang_count);
    depth_ext = CMP_W'(HOLD_DEPTH);
    if (hang_count == '0) begin
      hang_ext = CMP_W'(1);
    end else if (hc_ext > depth_ext) begin
      hang_ext = depth_ext;
    end else begin
      hang_ext = hc_ext;
    end
    fill_at_hang = (CMP_W'(fill_r) >= hang_ext) && (fill_r != '0);
  end

  // ring addressing, tail is head plus fill modulo depth
  always_comb begin
    head_inc = (head_r == ADDR_W'(HOLD_DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
    wr_sum   = (FILL_W+1)'(head_r) + (FILL_W+1)'(fill_r);
    if (wr_sum >= (FILL_W+1)'(HOLD_DEPTH)) begin
      wr_sum = wr_sum - (FILL_W+1)'(HOLD_DEPTH);
    end
    wr_addr = wr_sum[ADDR_W-1:0];
    rd_addr = head_r;
  end

  always_comb begin
    if (mag > {1'b0, close_level}) begin
      qrun_upd = '0;
    end else if (qrun_r == '1) begin
      qrun_upd = qrun_r;
    end else begin
      qrun_upd = qrun_r + QRUN_W'(1);
    end
  end

  always_comb begin
    ctl           = '0;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    gate_open_nxt = gate_open_r;
    qrun_nxt      = qrun_r;

    if (accept) begin
      if (open_level == '0) begin
        ctl.bypass = 1'b1;
      end else if (!gate_open_r) begin
        if (mag > {1'b0, open_level}) begin
          gate_open_nxt = 1'b1;
          qrun_nxt      = '0;
          ctl.pop       = fill_at_hang;
          ctl.push      = 1'b1;
        end
      end else begin
        qrun_nxt = qrun_upd;
        ctl.pop  = fill_at_hang;
        ctl.push = 1'b1;
      end

      if (ctl.pop) begin
        head_nxt = head_inc;
      end else if (ctl.push) begin
        fill_nxt = fill_r + FILL_W'(1);
      end

      // quiet run reached the hang: drop everything held and close
      if (gate_open_r && (open_level != '0) && (CMP_W'(qrun_upd) >= hang_ext)) begin
        head_nxt      = '0;
        fill_nxt      = '0;
        qrun_nxt      = '0;
        gate_open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      fill_r      <= '0;
      gate_open_r <= 1'b1;
      qrun_r      <= '0;
    end else begin
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      gate_open_r <= gate_open_nxt;
      qrun_r      <= qrun_nxt;
    end
  end

  `VGAC_ASSERT(a_fill_bound, clk, rst_n, fill_r <= FILL_W'(HOLD_DEPTH), "hold fill beyond depth")
  `VGAC_ASSERT(a_closed_empty, clk, rst_n, !gate_open_r |-> (fill_r == '0), "closed gate holds bytes")
  `VGAC_ASSERT(a_pop_nonempty, clk, rst_n, ctl.pop |-> (fill_r != '0), "pop from empty ring")

endmodule

`default_nettype wire

// ===== tb/sv/tb_voice_gated_alaw_codec.sv =====
// ----------------------------------------------------------------------------
// tb_voice_gated_alaw_codec
// self-checking bench: a table of directed transfers, then random phases of
// speech-like bursts and noise under random configurations, each output
// byte compared in order against a cycle-free model of codec, gate and ring
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voice_gated_alaw_codec;
  import vgac_pkg::*;

  localparam int RING_DEPTH    = 8192;
  localparam int STUCK_LIMIT   = 2000;   // cycles with no transfer at all
  localparam int SETTLE_CYCLES = 6;      // two-stage result path plus margin
  localparam int RANDOM_ITEMS  = 1250;
  localparam int LONG_HOLD     = 300;    // receiver hold-off in the fill phase
  localparam int MAX_REPORTS   = 20;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata   = '0;     // [7:0] sample_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;           // [7:0] sample_out
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  always #5 clk = ~clk;

  voice_gated_alaw_codec #(
    .HOLD_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // model state: register copies, delay ring, gate
  // ---------------------------------------------------------------------------
  logic                  cfg_dir    = 1'b0;
  logic [LVL_W-1:0]      lvl_open   = '0;
  logic [LVL_W-1:0]      lvl_close  = '0;
  logic [HANG_W-1:0]     hang_reg   = '0;

  logic [BYTE_W-1:0]     held_bytes [RING_DEPTH];
  int                    ring_head  = 0;
  int                    ring_fill  = 0;
  bit                    gate_is_open = 1'b1;
  int                    quiet_cnt  = 0;

  logic [BYTE_W-1:0]     pending_bytes [$];   // output bytes still owed by the block
  int                    fail_count = 0;

  // knobs shared by the sender, the receiver and the phase loop
  bit                    src_idle   = 1'b1;
  bit                    snk_idle   = 1'b1;
  int                    sink_hold  = 0;
  int                    run_left   = 0;
  bit                    run_loud   = 1'b0;

  function automatic logic [7:0] mirror_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[i];
    return r;
  endfunction

  // signed linear byte to a-law code; -128 saturates to magnitude 127
  function automatic logic [7:0] alaw_encode(input logic [7:0] s);
    logic [7:0]       m;
    logic [LVL_W-1:0] sat;
    m   = s[7] ? 8'(-s) : s;
    sat = (m > 8'd127) ? MAG_SAT : m[6:0];
    return (mirror_byte({1'b0, sat}) | {7'b0, ~s[7]}) ^ ALAW_XOR;
  endfunction

  // a-law code to signed linear byte; an even code is the negative side
  function automatic logic [7:0] alaw_decode(input logic [7:0] c);
    logic [7:0] v;
    logic [7:0] r;
    v = c ^ ALAW_XOR;
    r = mirror_byte(v);
    return v[0] ? {1'b0, r[6:0]} : 8'(-r);
  endfunction

  function automatic void ring_push(input logic [7:0] b);
    int slot;
    slot = ring_head + ring_fill;
    if (slot >= RING_DEPTH) slot -= RING_DEPTH;
    held_bytes[slot] = b;
    ring_fill++;
  endfunction

  function automatic logic [7:0] ring_pop();
    logic [7:0] b;
    b = held_bytes[ring_head];
    ring_head = (ring_head + 1 >= RING_DEPTH) ? 0 : ring_head + 1;
    ring_fill--;
    return b;
  endfunction

  // convert one byte and run it through gate and ring; returns 1 when a byte
  // leaves the block for this input
  function automatic bit gate_and_convert(input logic [7:0] s, output logic [7:0] res);
    logic [7:0] conv;
    logic [7:0] lin;
    logic [7:0] m;
    int         hang;
    bit         emit;
    emit = 1'b0;
    res  = '0;
    if (cfg_dir == 1'b0) begin
      lin  = s;
      conv = alaw_encode(s);
    end else begin
      conv = alaw_decode(s);
      lin  = conv;
    end
    // true magnitude, so -128 counts as 128 for the gate
    m = lin[7] ? 8'(-lin) : lin;

    // gating off: straight through, gate and ring stay frozen
    if (lvl_open == '0) begin
      res = conv;
      return 1'b1;
    end

    hang = (hang_reg == '0) ? 1 : int'(hang_reg);
    if (hang > RING_DEPTH) hang = RING_DEPTH;

    if (!gate_is_open) begin
      if (m > {1'b0, lvl_open}) begin
        // opening sample enters the ring with a fresh quiet run
        gate_is_open = 1'b1;
        quiet_cnt    = 0;
        if (ring_fill >= hang && ring_fill > 0) begin
          res  = ring_pop();
          emit = 1'b1;
        end
        ring_push(conv);
      end
      return emit;
    end

    if (m > {1'b0, lvl_close}) quiet_cnt = 0;
    else if (quiet_cnt < 65535) quiet_cnt++;

    if (ring_fill >= hang && ring_fill > 0) begin
      res  = ring_pop();
      emit = 1'b1;
    end
    ring_push(conv);

    // enough quiet in a row: drop everything held, loud bytes too
    if (quiet_cnt >= hang) begin
      ring_fill    = 0;
      ring_head    = 0;
      quiet_cnt    = 0;
      gate_is_open = 1'b0;
    end
    return emit;
  endfunction

  // talk spurts and pauses sized around the hang, with some raw noise
  function automatic logic [7:0] speech_byte();
    int         mag;
    int         lo;
    int         span;
    logic [7:0] lin;
    if ($urandom_range(0, 99) < 15) return 8'($urandom_range(0, 255));
    if (run_left == 0) begin
      span     = (hang_reg == '0) ? 1 : ((hang_reg > 16) ? 16 : int'(hang_reg));
      run_left = $urandom_range(1, 2 * span + 2);
      run_loud = $urandom_range(0, 1);
    end
    run_left--;
    lo  = ((lvl_open > lvl_close) ? int'(lvl_open) : int'(lvl_close)) + 1;
    mag = run_loud ? $urandom_range(lo, 128) : $urandom_range(0, lvl_close);
    lin = (mag == 128 || (mag != 0 && $urandom_range(0, 1) == 1)) ? 8'(-mag) : 8'(mag);
    return cfg_dir ? alaw_encode(lin) : lin;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offer one byte after a random gap; the model advances on the transfer.
  // in_tvalid stays high afterwards so back-to-back bytes need no re-raise
  task automatic send_byte(input logic [7:0] b, input bit fixed, input logic [7:0] want);
    int         gap;
    logic [7:0] res;
    bit         hit;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    hit = gate_and_convert(b, res);
    if (fixed) res = want;
    if (hit) begin
      pending_bytes.push_back(res);
    end
  endtask

  // stop offering, collect every owed byte, then let the ring stage settle
  // since a dropped byte may still be in flight
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input vgac_reg_t sel, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      REG_DIRECTION:   cfg_dir   = val[0];
      REG_OPEN_LEVEL:  lvl_open  = val[LVL_W-1:0];
      REG_CLOSE_LEVEL: lvl_close = val[LVL_W-1:0];
      REG_HANG_COUNT:  hang_reg  = val[HANG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random ready gaps, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : sink_proc
    int wait_n;
    while (!rst_n) @(posedge clk);
    forever begin
      wait_n = snk_idle ? $urandom_range(0, 6) : 0;
      if (sink_hold != 0) begin
        wait_n    = sink_hold;
        sink_hold = 0;
      end
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // ---------------------------------------------------------------------------
  // result check, oldest owed byte first
  // ---------------------------------------------------------------------------
  logic [7:0] owed;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected transfer, expected none, actual %02h", $time, out_tdata);
        fail_count++;
      end else begin
        owed = pending_bytes.pop_front();
        if (out_tdata !== owed) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: sample_out mismatch, expected %02h, actual %02h",
                     $time, owed, out_tdata);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any transfer on any channel counts as progress
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d bytes still owed",
               $time, STUCK_LIMIT, pending_bytes.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // directed table: a register write or a byte; known outputs are typed in,
  // the rest come from the model
  // ---------------------------------------------------------------------------
  typedef enum logic {
    ROW_WRITE,
    ROW_BYTE
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    vgac_reg_t              sel;
    logic [CFG_DATA_W-1:0]  value;   // register data, or the byte in [7:0]
    logic                   fixed;   // want holds the output byte
    logic [7:0]             want;
  } stim_row_t;

  localparam int DIR_ROWS = 34;

  stim_row_t directed_rows [DIR_ROWS] = '{
    // out of reset: encode, gating off, every byte passes at once
    '{ROW_BYTE,  REG_DIRECTION,   16'h0000, 1'b1, 8'hAB},   // zero
    '{ROW_BYTE,  REG_DIRECTION,   16'h007F, 1'b1, 8'h55},   // largest positive
    '{ROW_BYTE,  REG_DIRECTION,   16'h0080, 1'b1, 8'h54},   // -128 saturates
    '{ROW_BYTE,  REG_DIRECTION,   16'h00FF, 1'b1, 8'h2A},   // -1
    '{ROW_BYTE,  REG_DIRECTION,   16'h0001, 1'b1, 8'h2B},
    '{ROW_WRITE, REG_DIRECTION,   16'h0001, 1'b0, 8'h00},
    // decode side
    '{ROW_BYTE,  REG_DIRECTION,   16'h0055, 1'b1, 8'h7F},
    '{ROW_BYTE,  REG_DIRECTION,   16'h00AB, 1'b1, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h00AA, 1'b1, 8'h00},   // negative zero code
    '{ROW_BYTE,  REG_DIRECTION,   16'h0054, 1'b1, 8'h81},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0000, 1'b1, 8'hAB},
    '{ROW_BYTE,  REG_DIRECTION,   16'h00FF, 1'b1, 8'h2A},
    // gate on, zero hang acts as one
    '{ROW_WRITE, REG_DIRECTION,   16'h0000, 1'b0, 8'h00},
    '{ROW_WRITE, REG_CLOSE_LEVEL, 16'h000A, 1'b0, 8'h00},
    '{ROW_WRITE, REG_HANG_COUNT,  16'h0000, 1'b0, 8'h00},
    '{ROW_WRITE, REG_OPEN_LEVEL,  16'h0014, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0050, 1'b0, 8'h00},   // loud, held
    '{ROW_BYTE,  REG_DIRECTION,   16'h0005, 1'b0, 8'h00},   // quiet, closes
    '{ROW_BYTE,  REG_DIRECTION,   16'h0010, 1'b0, 8'h00},   // dropped while closed
    '{ROW_BYTE,  REG_DIRECTION,   16'h0080, 1'b0, 8'h00},   // -128 opens as 128
    '{ROW_BYTE,  REG_DIRECTION,   16'h0015, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h007F, 1'b0, 8'h00},
    // hang beyond the ring depth, all levels at the top
    '{ROW_WRITE, REG_HANG_COUNT,  16'hFFFF, 1'b0, 8'h00},
    '{ROW_WRITE, REG_CLOSE_LEVEL, 16'h007F, 1'b0, 8'h00},
    '{ROW_WRITE, REG_OPEN_LEVEL,  16'h007F, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0080, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0033, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0080, 1'b0, 8'h00},
    // shorter hang and a new direction while bytes are held
    '{ROW_WRITE, REG_HANG_COUNT,  16'h0002, 1'b0, 8'h00},
    '{ROW_WRITE, REG_DIRECTION,   16'h0001, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0055, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h00D5, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h002A, 1'b0, 8'h00},
    '{ROW_BYTE,  REG_DIRECTION,   16'h0080, 1'b0, 8'h00}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                    phase_no;
    int                    sent;
    int                    burst;
    int                    pick;
    logic                  new_dir;
    logic [LVL_W-1:0]      new_open;
    logic [LVL_W-1:0]      new_close;
    logic [HANG_W-1:0]     new_hang;
    bit                    fill_phase;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].sel, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].value[7:0], directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    // random phases: new settings, then a burst of speech-like bytes
    phase_no = 0;
    sent     = 0;
    while (sent < RANDOM_ITEMS) begin
      fill_phase = (phase_no == 3);
      new_dir    = $urandom_range(0, 1);

      pick = $urandom_range(0, 9);
      if (fill_phase || pick < 2) new_open = '0;
      else if (pick == 2)         new_open = 7'd127;
      else                        new_open = 7'($urandom_range(1, 100));

      pick = $urandom_range(0, 9);
      if (pick == 0)              new_close = '0;
      else if (pick == 1)         new_close = 7'd127;
      else if (new_open == '0)    new_close = 7'($urandom_range(0, 127));
      else                        new_close = 7'($urandom_range(0, new_open));

      pick = $urandom_range(0, 19);
      if (pick < 14)              new_hang = 16'($urandom_range(0, 6));
      else if (pick < 17)         new_hang = 16'($urandom_range(7, 40));
      else if (pick == 17)        new_hang = 16'hFFFF;
      else if (pick == 18)        new_hang = 16'(RING_DEPTH);
      else                        new_hang = 16'($urandom_range(0, 65535));

      wait_idle();
      write_reg(REG_DIRECTION,   CFG_DATA_W'(new_dir));
      write_reg(REG_OPEN_LEVEL,  CFG_DATA_W'(new_open));
      write_reg(REG_CLOSE_LEVEL, CFG_DATA_W'(new_close));
      write_reg(REG_HANG_COUNT,  CFG_DATA_W'(new_hang));

      if (fill_phase) begin
        // receiver holds off after its next transfer while bytes keep coming,
        // so the output register and ring stage fill and in_tready drops
        src_idle  = 1'b0;
        snk_idle  = 1'b0;
        sink_hold = LONG_HOLD;
        burst     = 120;
      end else begin
        src_idle = ($urandom_range(0, 3) != 0);
        snk_idle = ($urandom_range(0, 3) != 0);
        burst    = (new_hang > 40) ? $urandom_range(10, 40) : $urandom_range(20, 80);
      end

      run_left = 0;
      repeat (burst) begin
        send_byte(speech_byte(), 1'b0, 8'h00);
        sent++;
      end
      phase_no++;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
